### sv/lrut_pkg.sv
// shared constants, types and codes for the bounded lru id tracker
// no dependencies
package lrut_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ID_W    = 64;
    localparam int MAX_W   = 7;
    localparam int ENTRY_W = 7;
    localparam logic [MAX_W-1:0] MAX_RESET = 7'd64;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic    ld_req;
        logic    clr_idx;
        logic    inc_idx;
        logic    dec_idx;
        logic    rd_srch;
        logic    rd_shift;
        logic    rd_pop;
        logic    wr_shift;
        logic    wr_head;
        logic    cnt_inc;
        logic    fin;
        t_status fin_st;
        logic    pop_ok;
        logic    set_ovf;
    } t_dp_cmd;

    typedef struct packed {
        logic is_pop;
        logic cnt_zero;
        logic full;
        logic srch_end;
        logic hit;
        logic idx_zero;
        logic out_free;
    } t_dp_sts;

endpackage

### sv/lrut_req_if.sv
// request channel: command and identifier with valid/ready
// depends on lrut_pkg
interface lrut_req_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [lrut_pkg::ID_W-1:0] file_id;

    modport source (output valid, output cmd, output file_id, input ready);
    modport sink   (input valid, input cmd, input file_id, output ready);
endinterface

### sv/lrut_rsp_if.sv
// response channel: status, popped id and list state with valid/ready
// depends on lrut_pkg
interface lrut_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [lrut_pkg::ID_W-1:0]    popped_id;
    logic [lrut_pkg::ENTRY_W-1:0] entry_count;
    logic                         is_empty;
    logic                         overflow_seen;

    modport source (output valid, output status, output popped_id, output entry_count,
                    output is_empty, output overflow_seen, input ready);
    modport sink   (input valid, input status, input popped_id, input entry_count,
                    input is_empty, input overflow_seen, output ready);
endinterface

### sv/lrut_ctrl.sv
// controller state machine: sequences search, shift, insert and pop
// depends on lrut_pkg
module lrut_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  lrut_pkg::t_dp_sts i_sts,
    output lrut_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_DISP      = 11'b000_0000_0010,
        S_SRCH_RD   = 11'b000_0000_0100,
        S_SRCH_CMP  = 11'b000_0000_1000,
        S_SH_CHK    = 11'b000_0001_0000,
        S_SH_WR     = 11'b000_0010_0000,
        S_HEAD_WR   = 11'b000_0100_0000,
        S_FIN_OK    = 11'b000_1000_0000,
        S_FIN_POP   = 11'b001_0000_0000,
        S_FIN_EMPTY = 11'b010_0000_0000,
        S_FIN_FULL  = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.fin_st = lrut_pkg::ST_DONE;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.ld_req  = 1'b1;
                    o_cmd.clr_idx = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.is_pop) begin
                    if (i_sts.cnt_zero) begin
                        n_state = S_FIN_EMPTY;
                    end else begin
                        o_cmd.rd_pop = 1'b1;
                        n_state      = S_FIN_POP;
                    end
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (i_sts.srch_end) begin
                    if (i_sts.full) begin
                        n_state = S_FIN_FULL;
                    end else begin
                        // miss with room: insert, shifting the whole list
                        o_cmd.cnt_inc = 1'b1;
                        n_state       = S_SH_CHK;
                    end
                end else begin
                    o_cmd.rd_srch = 1'b1;
                    n_state       = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (i_sts.hit) begin
                    n_state = S_SH_CHK;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = S_SRCH_RD;
                end
            end
            S_SH_CHK: begin
                if (i_sts.idx_zero) begin
                    n_state = S_HEAD_WR;
                end else begin
                    o_cmd.rd_shift = 1'b1;
                    n_state        = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.dec_idx  = 1'b1;
                n_state        = S_SH_CHK;
            end
            S_HEAD_WR: begin
                o_cmd.wr_head = 1'b1;
                n_state       = S_FIN_OK;
            end
            S_FIN_OK: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_FIN_POP: begin
                if (i_sts.out_free) begin
                    o_cmd.fin    = 1'b1;
                    o_cmd.pop_ok = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FIN_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.fin    = 1'b1;
                    o_cmd.fin_st = lrut_pkg::ST_EMPTY;
                    n_state      = S_IDLE;
                end
            end
            S_FIN_FULL: begin
                if (i_sts.out_free) begin
                    o_cmd.fin     = 1'b1;
                    o_cmd.fin_st  = lrut_pkg::ST_FULL;
                    o_cmd.set_ovf = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/lrut_dp.sv
// datapath: id memory, count, overflow flag, limit register and response register
// depends on lrut_pkg and lrut_rsp_if
module lrut_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrut_pkg::t_dp_cmd             i_cmd,
    output lrut_pkg::t_dp_sts             o_sts,
    input  logic                          i_req_cmd,
    input  logic [lrut_pkg::ID_W-1:0]     i_req_id,
    input  logic                          i_cfg_we,
    input  logic [lrut_pkg::MAX_W-1:0]    i_cfg_wdata,
    lrut_rsp_if.source                    o_rsp
);

    logic [lrut_pkg::ID_W-1:0]    r_mem [lrut_pkg::DEPTH];
    logic [lrut_pkg::ID_W-1:0]    r_rd_data;
    logic [lrut_pkg::ID_W-1:0]    r_id;
    logic                         r_is_pop;
    logic [lrut_pkg::CNT_W-1:0]   r_idx;
    logic [lrut_pkg::CNT_W-1:0]   r_cnt;
    logic                         r_ovf;
    logic [lrut_pkg::MAX_W-1:0]   r_max;

    logic                         r_ov;
    lrut_pkg::t_status            r_st;
    logic [lrut_pkg::ID_W-1:0]    r_pop_id;
    logic [lrut_pkg::CNT_W-1:0]   r_ocnt;
    logic                         r_oovf;

    logic [lrut_pkg::CNT_W-1:0]   n_cnt;
    logic                         n_ovf;
    logic [lrut_pkg::IDX_W-1:0]   w_rd_addr;
    logic [lrut_pkg::IDX_W-1:0]   w_wr_addr;
    logic [lrut_pkg::ID_W-1:0]    w_wr_data;
    logic [lrut_pkg::CNT_W-1:0]   w_idx_m1;
    logic [lrut_pkg::CNT_W-1:0]   w_cnt_m1;
    logic [31:0]                  w_max32;
    logic [31:0]                  w_lim32;
    logic                         w_rd_en;
    logic                         w_wr_en;
    logic                         w_out_free;

    assign w_idx_m1 = r_idx - lrut_pkg::CNT_W'(1);
    assign w_cnt_m1 = r_cnt - lrut_pkg::CNT_W'(1);
    assign w_max32  = 32'(r_max);
    assign w_lim32  = (w_max32 < 32'(lrut_pkg::DEPTH)) ? w_max32 : 32'(lrut_pkg::DEPTH);

    assign w_rd_en = i_cmd.rd_srch | i_cmd.rd_shift | i_cmd.rd_pop;
    always_comb begin
        w_rd_addr = r_idx[lrut_pkg::IDX_W-1:0];
        if (i_cmd.rd_shift) begin
            w_rd_addr = w_idx_m1[lrut_pkg::IDX_W-1:0];
        end else if (i_cmd.rd_pop) begin
            w_rd_addr = w_cnt_m1[lrut_pkg::IDX_W-1:0];
        end
    end

    assign w_wr_en   = i_cmd.wr_shift | i_cmd.wr_head;
    assign w_wr_addr = i_cmd.wr_head ? '0 : r_idx[lrut_pkg::IDX_W-1:0];
    assign w_wr_data = i_cmd.wr_head ? r_id : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_id     <= i_req_id;
            r_is_pop <= (i_req_cmd == lrut_pkg::CMD_POP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_idx) begin
            r_idx <= '0;
        end else if (i_cmd.inc_idx) begin
            r_idx <= r_idx + lrut_pkg::CNT_W'(1);
        end else if (i_cmd.dec_idx) begin
            r_idx <= w_idx_m1;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + lrut_pkg::CNT_W'(1);
        end else if (i_cmd.pop_ok) begin
            n_cnt = w_cnt_m1;
        end
        n_ovf = r_ovf;
        if (i_cmd.set_ovf) begin
            n_ovf = 1'b1;
        end else if (i_cmd.pop_ok) begin
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_max <= lrut_pkg::MAX_RESET;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

    assign w_out_free = !r_ov || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.fin) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_st     <= i_cmd.fin_st;
            r_pop_id <= i_cmd.pop_ok ? r_rd_data : '0;
            r_ocnt   <= n_cnt;
            r_oovf   <= n_ovf;
        end
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.status        = r_st;
    assign o_rsp.popped_id     = r_pop_id;
    assign o_rsp.entry_count   = lrut_pkg::ENTRY_W'(r_ocnt);
    assign o_rsp.is_empty      = (r_ocnt == '0);
    assign o_rsp.overflow_seen = r_oovf;

    assign o_sts.is_pop   = r_is_pop;
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.full     = (32'(r_cnt) >= w_lim32);
    assign o_sts.srch_end = (r_idx == r_cnt);
    assign o_sts.hit      = (r_rd_data == r_id);
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.out_free = w_out_free;

endmodule

### sv/bounded_lru_id_tracker_top.sv
// top level of the bounded lru id tracker: controller plus datapath
// depends on lrut_pkg, lrut_req_if, lrut_rsp_if, lrut_ctrl, lrut_dp
//
//   channel   dir   fields                                               handshake
//   i_req     in    cmd, file_id                                         valid / ready
//   o_rsp     out   status, popped_id, entry_count, is_empty, overflow   valid / ready
//   i_cfg     in    i_cfg_wdata (max_entries)                            i_cfg_we
//
// one request at a time; the controller walks the id memory entry by entry for each request
// pop: read the tail (least recent) entry; hit: search, shift the entries before it, write the head
// insert: search misses, shift every entry, write the head; dropped: search misses on a full list
// a finished response sits in the output register while the next request is taken
// response stall holds the next request in its final state until the register frees
// synchronous active-low reset clears count, overflow flag, limit (to 64) and response
module bounded_lru_id_tracker_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lrut_req_if.sink                      i_req,
    lrut_rsp_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [lrut_pkg::MAX_W-1:0]    i_cfg_wdata
);

    lrut_pkg::t_dp_cmd w_cmd;
    lrut_pkg::t_dp_sts w_sts;
    logic              w_req_ready;

    assign i_req.ready = w_req_ready;

    lrut_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lrut_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req_cmd   (i_req.cmd),
        .i_req_id    (i_req.file_id),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (o_rsp)
    );

endmodule
